// ===== design/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the point-in-polygon test block.
// ----------------------------------------------------------------------------
package pip_pkg;

  // Vertex store capacity and derived widths
  localparam int MAX_VERTICES = 64;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int COORD_W      = 16;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // One stored vertex
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } vertex_t;

  // Sequencer to edge unit control
  typedef struct packed {
    logic start;   // new query: clear crossing parity
    logic vld;     // read data valid this cycle
    logic first;   // read data only seeds the previous vertex
  } pip_ctl_t;

  // Edge unit status back to the sequencer
  typedef struct packed {
    logic busy;    // an edge is still in the pipeline
    logic parity;  // running crossing parity
  } pip_sts_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_DONE
  } pip_state_t;

endpackage

// ===== design/pip_vertex_mem.sv =====
// ----------------------------------------------------------------------------
// pip_vertex_mem
// Vertex store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pip_vertex_mem
  import pip_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  vertex_t          wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output vertex_t          rd_data
);

  vertex_t mem [MAX_VERTICES];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/pip_edge_unit.sv =====
// ----------------------------------------------------------------------------
// pip_edge_unit
// Shared crossing test: one edge per cycle through a three-step pipeline
// (differences, products, compare) that toggles the crossing parity.
// ----------------------------------------------------------------------------
module pip_edge_unit
  import pip_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  pip_ctl_t                  ctl,
  input  vertex_t                   cur,      // vertex i from the store
  input  logic signed [COORD_W-1:0] tx,
  input  logic signed [COORD_W-1:0] ty,
  output pip_sts_t                  sts
);

  vertex_t                  prev;
  logic                     s1_vld;
  logic                     s1_straddle;
  logic                     s1_up;
  logic signed [DIFF_W-1:0] s1_dy;
  logic signed [DIFF_W-1:0] s1_dxt;
  logic signed [DIFF_W-1:0] s1_dxb;
  logic signed [DIFF_W-1:0] s1_dyt;
  logic                     s2_vld;
  logic                     s2_straddle;
  logic                     s2_up;
  logic signed [PROD_W-1:0] s2_lhs;
  logic signed [PROD_W-1:0] s2_rhs;
  logic                     parity;
  logic                     crosses;

  // sign-extended operands
  logic signed [DIFF_W-1:0] ax_e, ay_e, bx_e, by_e, tx_e, ty_e;
  assign ax_e = {cur.x[COORD_W-1], cur.x};
  assign ay_e = {cur.y[COORD_W-1], cur.y};
  assign bx_e = {prev.x[COORD_W-1], prev.x};
  assign by_e = {prev.y[COORD_W-1], prev.y};
  assign tx_e = {tx[COORD_W-1], tx};
  assign ty_e = {ty[COORD_W-1], ty};

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s1_vld <= ctl.vld && !ctl.first;
      s2_vld <= s1_vld;
    end
  end

  // step 1: previous vertex and differences
  always_ff @(posedge clk) begin
    if (ctl.vld) begin
      prev        <= cur;
      s1_straddle <= (cur.y > ty) != (prev.y > ty);
      s1_up       <= prev.y > cur.y;
      s1_dy       <= by_e - ay_e;
      s1_dxt      <= tx_e - ax_e;
      s1_dxb      <= bx_e - ax_e;
      s1_dyt      <= ty_e - ay_e;
    end
  end

  // step 2: cross products
  always_ff @(posedge clk) begin
    s2_straddle <= s1_straddle;
    s2_up       <= s1_up;
    s2_lhs      <= PROD_W'(s1_dxt) * PROD_W'(s1_dy);
    s2_rhs      <= PROD_W'(s1_dxb) * PROD_W'(s1_dyt);
  end

  // step 3: compare, direction of the edge picks the sense
  assign crosses = s2_straddle && (s2_up ? (s2_lhs < s2_rhs) : (s2_lhs > s2_rhs));

  always_ff @(posedge clk) begin
    if (rst) begin
      parity <= 1'b0;
    end else if (ctl.start) begin
      parity <= 1'b0;
    end else if (s2_vld && crosses) begin
      parity <= !parity;
    end
  end

  assign sts.busy   = s1_vld || s2_vld;
  assign sts.parity = parity;

endmodule

// ===== design/point_in_polygon_test.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Even-odd ray-casting point-in-polygon test over a stored vertex list.
//
//   port group    dir   beat contents
//   in_*          in    command, vertex_index, coord_x, coord_y
//   out_*         out   inside_res (one beat per query)
//   cfg_wr_*      in    vertex_count
//
// A write beat is taken while idle and does not start the sequencer. A query
// with n >= 1 vertices in use holds in_stall through n + 1 reads from the
// store's single read port (vertex n-1 first, to seed the wrapping edge), while
// the last edge clears the read register and the two pipeline steps, and while
// the result is loaded. With no vertices in use a query goes straight to the done state.
// The result waits in an output register; the next beat can be taken while it
// waits, and a further result stays in the done state until that register frees.
// rst is synchronous and clears control state; the vertex store is not
// cleared and holds garbage until written.
// ----------------------------------------------------------------------------
module point_in_polygon_test
  import pip_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [CNT_W-1:0]          cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      command,
  input  logic [IDX_W-1:0]          vertex_index,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      inside_res
);

  pip_state_t                state, state_next;
  logic [CNT_W-1:0]          vertex_count;
  logic [CNT_W-1:0]          n_sat;
  logic [CNT_W-1:0]          q_n;
  logic [CNT_W-1:0]          rd_cnt, rd_cnt_next;
  logic signed [COORD_W-1:0] tx;
  logic signed [COORD_W-1:0] ty;
  logic                      in_acc;
  logic                      query_acc;
  logic                      wr_en;
  logic                      rd_en;
  logic [IDX_W-1:0]          rd_addr;
  logic                      issue_vld;
  logic                      issue_first;
  logic                      load_res;
  vertex_t                   wr_data;
  vertex_t                   rd_data;
  pip_ctl_t                  ctl;
  pip_sts_t                  sts;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_wr_en) begin
      vertex_count <= cfg_wr_data;
    end
  end

  assign n_sat = (vertex_count > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                       : vertex_count;

  // input handshake
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign query_acc = in_acc && (command == CMD_QUERY);
  assign wr_en     = in_acc && (command == CMD_WRITE)
                     && ({1'b0, vertex_index} < CNT_W'(MAX_VERTICES));
  assign wr_data   = '{x: coord_x, y: coord_y};

  // query registers
  always_ff @(posedge clk) begin
    if (query_acc) begin
      tx  <= coord_x;
      ty  <= coord_y;
      q_n <= n_sat;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rd_cnt      <= '0;
      issue_vld   <= 1'b0;
      issue_first <= 1'b0;
    end else begin
      state       <= state_next;
      rd_cnt      <= rd_cnt_next;
      issue_vld   <= rd_en;
      issue_first <= rd_en && (rd_cnt == '0);
    end
  end

  // sequencer: first read is vertex n-1, then 0 .. n-1
  always_comb begin
    state_next  = state;
    rd_cnt_next = rd_cnt;
    rd_en       = 1'b0;
    rd_addr     = '0;
    load_res    = 1'b0;
    case (state)
      S_IDLE: begin
        rd_cnt_next = '0;
        if (query_acc) begin
          state_next = (n_sat == '0) ? S_DONE : S_READ;
        end
      end
      S_READ: begin
        rd_en       = 1'b1;
        rd_addr     = (rd_cnt == '0) ? IDX_W'(q_n - 1'b1) : IDX_W'(rd_cnt - 1'b1);
        rd_cnt_next = rd_cnt + 1'b1;
        if (rd_cnt == q_n) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!issue_vld && !sts.busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          load_res   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_res) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      inside_res <= sts.parity;
    end
  end

  assign ctl.start = query_acc;
  assign ctl.vld   = issue_vld;
  assign ctl.first = issue_first;

  pip_vertex_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (vertex_index),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pip_edge_unit u_edge (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .cur (rd_data),
    .tx  (tx),
    .ty  (ty),
    .sts (sts)
  );

  // a query beat always starts the sequencer
  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    query_acc |=> (state != S_IDLE))
    else $error("query accepted but sequencer stayed idle");

  // a result appears only out of the done state
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result raised outside done state");

  // read counter never runs past the vertex count
  a_rd_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (rd_cnt <= q_n))
    else $error("read counter beyond vertex count");

  // no edge left in flight when the result is taken
  a_drained: assert property (@(posedge clk) disable iff (rst)
    load_res |-> (!issue_vld && !sts.busy))
    else $error("result loaded with edges in flight");

endmodule
